// ===== rtl/core/scaled_fixed_step_tick_accumulator_defines.svh =====
// Assertion helpers shared by the RTL that checks itself.
`ifndef SCALED_FIXED_STEP_TICK_ACCUMULATOR_DEFINES_SVH
`define SCALED_FIXED_STEP_TICK_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STFTA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define STFTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/stfta_pkg.sv =====
package stfta_pkg;

   // Field widths of one input beat and one result beat
   localparam int MODE_W  = 3;
   localparam int TIME_W  = 32;
   localparam int STEP_W  = 17;
   localparam int SCALE_W = 16;
   localparam int TICK_W  = 20;
   localparam int ALPHA_W = 16;
   localparam int RATE_W  = 10;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   typedef logic [MODE_W-1:0]    mode_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam mode_type MODE_ADVANCE = 3'd0;
   localparam mode_type MODE_QUICK   = 3'd1;
   localparam mode_type MODE_SKIP    = 3'd2;
   localparam mode_type MODE_STEPS   = 3'd3;
   localparam mode_type MODE_SCALE   = 3'd4;

   localparam csr_idx_type CSR_TICK_RATE = 1'd0;
   localparam csr_idx_type CSR_MAX_TICKS = 1'd1;

   // Q4.12 time scale
   localparam int                 SCALE_SHIFT = 12;
   localparam logic [SCALE_W-1:0] SCALE_ONE   = 16'd4096;
   localparam logic [SCALE_W-1:0] SCALE_MAX   = 16'd40960;

   localparam logic [9:0]        MS_CAP      = 10'd1000;
   localparam logic [STEP_W-1:0] STEPS_IDLE  = 17'h1FFFF;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic elapsed;
      logic step_adv;
      logic set_steps;
      logic set_scale;
      logic rate_mul;
      logic scale_mul;
      logic frac_div;
      logic inc_fine;
      logic inc_quick;
      logic add_phase;
      logic take_whole;
      logic load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      mode_type mode;
      logic     stepping;
   } status_type;

endpackage

// ===== rtl/core/stfta_req_if.sv =====
interface stfta_req_if import stfta_pkg::*; ();
   logic                      valid;
   logic                      ready;
   mode_type                  mode;
   logic [TIME_W-1:0]         now_ms;
   logic signed [STEP_W-1:0]  step_count;
   logic [SCALE_W-1:0]        scale_value;

   modport source (output valid, mode, now_ms, step_count, scale_value, input ready);
   modport sink   (input valid, mode, now_ms, step_count, scale_value, output ready);
endinterface

// ===== rtl/core/stfta_rsp_if.sv =====
interface stfta_rsp_if import stfta_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TICK_W-1:0]   ticks;
   logic [ALPHA_W-1:0]  alpha;
   logic                is_stepping;
   logic [SCALE_W-1:0]  scale_now;

   modport source (output valid, ticks, alpha, is_stepping, scale_now, input ready);
   modport sink   (input valid, ticks, alpha, is_stepping, scale_now, output ready);
endinterface

// ===== rtl/core/stfta_div1000.sv =====
// Two-stage divide by 1000: reciprocal multiply, then one correction step.
module stfta_div1000 #(
   parameter int DIV_W = 26
) (
   input  logic               clock,
   input  logic [DIV_W-1:0]   x,
   output logic [DIV_W-10:0]  quo,
   output logic [9:0]         rem
);

   localparam int QW = DIV_W - 9;
   localparam longint unsigned RECIP_L = (longint'(1) << DIV_W) / 1000;
   localparam logic [QW-1:0] RECIP = RECIP_L[QW-1:0];
   localparam logic [10:0] DIVISOR = 11'd1000;

   logic [DIV_W+QW-1:0] prod;
   logic [QW-1:0]       q0_in, q0_ff;
   logic [10:0]         x_lo_in, x_lo_ff;
   logic [10:0]         q0_k;
   logic [10:0]         r0;
   logic [QW-1:0]       quo_in, quo_ff;
   logic [9:0]          rem_in, rem_ff;

   // Estimate: at most one below the true quotient
   always_comb begin
      prod    = x * RECIP;
      q0_in   = prod[DIV_W+QW-1:DIV_W];
      x_lo_in = x[10:0];
   end

   // Remainder fits in 11 bits, so work modulo 2^11
   always_comb begin
      q0_k   = 11'(q0_ff[10:0] * DIVISOR);
      r0     = x_lo_ff - q0_k;
      quo_in = q0_ff;
      rem_in = r0[9:0];
      if (r0 >= DIVISOR) begin
         quo_in = q0_ff + QW'(1);
         rem_in = 10'(r0 - DIVISOR);
      end
   end

   always_ff @(posedge clock) begin
      q0_ff   <= q0_in;
      x_lo_ff <= x_lo_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule

// ===== rtl/core/stfta_ctrl.sv =====
// Sequencer: walks one item through the datapath and owns both handshakes.
module stfta_ctrl import stfta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_RATE   = 4'd2;
   localparam logic [3:0] ST_DIV1A  = 4'd3;
   localparam logic [3:0] ST_DIV1B  = 4'd4;
   localparam logic [3:0] ST_SCALE  = 4'd5;
   localparam logic [3:0] ST_DIV2A  = 4'd6;
   localparam logic [3:0] ST_DIV2B  = 4'd7;
   localparam logic [3:0] ST_FRAC   = 4'd8;
   localparam logic [3:0] ST_DIV3A  = 4'd9;
   localparam logic [3:0] ST_DIV3B  = 4'd10;
   localparam logic [3:0] ST_INC    = 4'd11;
   localparam logic [3:0] ST_QUICK  = 4'd12;
   localparam logic [3:0] ST_ADD    = 4'd13;
   localparam logic [3:0] ST_TAKE   = 4'd14;
   localparam logic [3:0] ST_DONE   = 4'd15;

   logic [3:0] state_in, state_ff;
   logic       rsp_valid_in, rsp_valid_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.mode)
               MODE_ADVANCE: begin
                  if (status.stepping) begin
                     cmd.step_adv = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     cmd.elapsed = 1'b1;
                     state_in    = ST_RATE;
                  end
               end
               MODE_SKIP: begin
                  cmd.elapsed = 1'b1;
                  state_in    = ST_RATE;
               end
               MODE_QUICK: state_in = ST_QUICK;
               MODE_STEPS: begin
                  cmd.set_steps = 1'b1;
                  state_in      = ST_DONE;
               end
               MODE_SCALE: begin
                  cmd.set_scale = 1'b1;
                  state_in      = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_RATE: begin
            cmd.rate_mul = 1'b1;
            state_in     = ST_DIV1A;
         end
         ST_DIV1A: state_in = ST_DIV1B;
         ST_DIV1B: state_in = ST_SCALE;
         ST_SCALE: begin
            cmd.scale_mul = 1'b1;
            state_in      = ST_DIV2A;
         end
         ST_DIV2A: state_in = ST_DIV2B;
         ST_DIV2B: state_in = ST_FRAC;
         ST_FRAC: begin
            cmd.frac_div = 1'b1;
            state_in     = ST_DIV3A;
         end
         ST_DIV3A: state_in = ST_DIV3B;
         ST_DIV3B: state_in = ST_INC;
         ST_INC: begin
            cmd.inc_fine = 1'b1;
            state_in     = ST_ADD;
         end
         ST_QUICK: begin
            cmd.inc_quick = 1'b1;
            state_in      = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_phase = 1'b1;
            state_in      = (status.mode == MODE_SKIP) ? ST_DONE : ST_TAKE;
         end
         ST_TAKE: begin
            cmd.take_whole = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the result register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result beat valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/stfta_dpath.sv =====
// Datapath: accumulator state, fixed-point arithmetic and result register.
module stfta_dpath import stfta_pkg::*; #(
   parameter int TICK_LIMIT = 1000000,
   parameter int FRAC_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  mode_type                  req_mode,
   input  logic [TIME_W-1:0]         req_now_ms,
   input  logic signed [STEP_W-1:0]  req_step_count,
   input  logic [SCALE_W-1:0]        req_scale_value,
   input  logic                      csr_we,
   input  csr_idx_type               csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output logic [TICK_W-1:0]         rsp_ticks,
   output logic [ALPHA_W-1:0]        rsp_alpha,
   output logic                      rsp_is_stepping,
   output logic [SCALE_W-1:0]        rsp_scale_now
);

   localparam int PHASE_W = 32 + FRAC_BITS;
   localparam int DIV_W   = (FRAC_BITS + 10 > 26) ? FRAC_BITS + 10 : 26;
   localparam int QUO_W   = DIV_W - 9;
   localparam int ACC_W   = 26;
   localparam logic [TICK_W-1:0] TICK_CAP = TICK_W'(TICK_LIMIT);

   // Latched input beat
   mode_type             item_mode_in, item_mode_ff;
   logic [TIME_W-1:0]    item_now_in, item_now_ff;
   logic [STEP_W-1:0]    item_steps_in, item_steps_ff;
   logic [SCALE_W-1:0]   item_scale_in, item_scale_ff;

   // Configuration and architectural state
   logic [RATE_W-1:0]    tick_rate_in, tick_rate_ff;
   logic [TICK_W-1:0]    max_ticks_in, max_ticks_ff;
   logic [TIME_W-1:0]    last_time_in, last_time_ff;
   logic [PHASE_W-1:0]   phase_in, phase_ff;
   logic [SCALE_W-1:0]   time_scale_in, time_scale_ff;
   logic [STEP_W-1:0]    steps_left_in, steps_left_ff;
   logic [TICK_W-1:0]    last_ticks_in, last_ticks_ff;
   logic [ALPHA_W-1:0]   last_alpha_in, last_alpha_ff;

   // Working registers
   logic [9:0]           ms_in, ms_ff;
   logic [DIV_W-1:0]     div_x_in, div_x_ff;
   logic [ACC_W-1:0]     qs_in, qs_ff;
   logic [ACC_W-1:0]     acc_in, acc_ff;
   logic [PHASE_W-1:0]   inc_in, inc_ff;

   // Result register
   logic [TICK_W-1:0]    out_ticks_in, out_ticks_ff;
   logic [ALPHA_W-1:0]   out_alpha_in, out_alpha_ff;
   logic                 out_step_in, out_step_ff;
   logic [SCALE_W-1:0]   out_scale_in, out_scale_ff;

   // Combinational terms
   logic [QUO_W-1:0]            div_q;
   logic [9:0]                  div_r;
   logic [TICK_W-1:0]           cap_ticks;
   logic [TIME_W-1:0]           gap;
   logic [9:0]                  elapsed_ms;
   logic [19:0]                 rate_prod;
   logic [ACC_W-1:0]            whole_prod;
   logic [ACC_W-1:0]            rem_prod;
   logic [FRAC_BITS+9:0]        frac_num;
   logic [ACC_W+FRAC_BITS-1:0]  fine_cat;
   logic [PHASE_W-1:0]          fine_inc;
   logic [35:0]                 quick_prod;
   logic [36+FRAC_BITS-1:0]     quick_cat;
   logic [PHASE_W-1:0]          quick_inc;
   logic [PHASE_W:0]            sum_ext;
   logic [PHASE_W-1:0]          phase_sat;
   logic [31:0]                 whole;
   logic [FRAC_BITS-1:0]        frac;
   logic [FRAC_BITS+15:0]       alpha_ext;
   logic [TICK_W-1:0]           tick_lim;
   logic [TICK_W-1:0]           take_ticks;

   stfta_div1000 #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock (clock),
      .x     (div_x_ff),
      .quo   (div_q),
      .rem   (div_r)
   );

   assign status.mode     = item_mode_ff;
   assign status.stepping = !steps_left_ff[STEP_W-1];

   // Arithmetic terms
   always_comb begin
      cap_ticks  = (max_ticks_ff > TICK_CAP) ? TICK_CAP : max_ticks_ff;
      gap        = item_now_ff - last_time_ff;
      if (item_now_ff < last_time_ff) begin
         elapsed_ms = '0;
      end else if (gap > TIME_W'(MS_CAP)) begin
         elapsed_ms = MS_CAP;
      end else begin
         elapsed_ms = gap[9:0];
      end
      // ms * rate, split by 1000, then each part times the scale
      rate_prod  = ms_ff * tick_rate_ff;
      whole_prod = div_q[9:0] * time_scale_ff;
      rem_prod   = div_r * time_scale_ff;
      frac_num   = {div_r, {FRAC_BITS{1'b0}}};
      // Quotient by 1000 joined with the fraction digits, then drop Q4.12
      fine_cat   = {acc_ff, div_q[FRAC_BITS-1:0]};
      fine_inc   = PHASE_W'(fine_cat >> SCALE_SHIFT);
      quick_prod = cap_ticks * time_scale_ff;
      quick_cat  = {quick_prod, {FRAC_BITS{1'b0}}};
      quick_inc  = PHASE_W'(quick_cat >> SCALE_SHIFT);
      // Saturating phase add
      sum_ext    = {1'b0, phase_ff} + {1'b0, inc_ff};
      phase_sat  = sum_ext[PHASE_W] ? '1 : sum_ext[PHASE_W-1:0];
      // Whole ticks and alpha from the phase
      whole      = phase_ff[PHASE_W-1:FRAC_BITS];
      frac       = phase_ff[FRAC_BITS-1:0];
      alpha_ext  = {frac, 16'h0000};
      tick_lim   = (item_mode_ff == MODE_QUICK) ? TICK_CAP : cap_ticks;
      take_ticks = (whole > 32'(tick_lim)) ? tick_lim : whole[TICK_W-1:0];
   end

   // Next values
   always_comb begin
      item_mode_in  = item_mode_ff;
      item_now_in   = item_now_ff;
      item_steps_in = item_steps_ff;
      item_scale_in = item_scale_ff;
      tick_rate_in  = tick_rate_ff;
      max_ticks_in  = max_ticks_ff;
      last_time_in  = last_time_ff;
      phase_in      = phase_ff;
      time_scale_in = time_scale_ff;
      steps_left_in = steps_left_ff;
      last_ticks_in = last_ticks_ff;
      last_alpha_in = last_alpha_ff;
      ms_in         = ms_ff;
      div_x_in      = div_x_ff;
      qs_in         = qs_ff;
      acc_in        = acc_ff;
      inc_in        = inc_ff;
      out_ticks_in  = out_ticks_ff;
      out_alpha_in  = out_alpha_ff;
      out_step_in   = out_step_ff;
      out_scale_in  = out_scale_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TICK_RATE: tick_rate_in = csr_wdata[RATE_W-1:0];
            CSR_MAX_TICKS: max_ticks_in = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end

      if (cmd.accept) begin
         item_mode_in  = req_mode;
         item_now_in   = req_now_ms;
         item_steps_in = req_step_count;
         item_scale_in = req_scale_value;
      end

      // Clamp elapsed time and resync
      if (cmd.elapsed) begin
         ms_in        = elapsed_ms;
         last_time_in = item_now_ff;
         if (item_mode_ff == MODE_SKIP) begin
            last_ticks_in = '0;
         end
      end

      // One tick per advance while steps remain, none once the count is zero
      if (cmd.step_adv) begin
         if (steps_left_ff == '0) begin
            last_ticks_in = '0;
            last_alpha_in = '0;
         end else begin
            last_ticks_in = TICK_W'(1);
            steps_left_in = steps_left_ff - STEP_W'(1);
         end
      end

      if (cmd.set_steps) begin
         if (item_steps_ff[STEP_W-1]) begin
            steps_left_in = STEPS_IDLE;
            last_time_in  = item_now_ff;
            phase_in      = '0;
            time_scale_in = SCALE_ONE;
         end else begin
            steps_left_in = item_steps_ff;
         end
      end

      if (cmd.set_scale) begin
         time_scale_in = (item_scale_ff > SCALE_MAX) ? SCALE_MAX : item_scale_ff;
      end

      if (cmd.rate_mul) begin
         div_x_in = DIV_W'(rate_prod);
      end

      if (cmd.scale_mul) begin
         qs_in    = whole_prod;
         div_x_in = DIV_W'(rem_prod);
      end

      if (cmd.frac_div) begin
         acc_in   = qs_ff + ACC_W'(div_q);
         div_x_in = DIV_W'(frac_num);
      end

      if (cmd.inc_fine) begin
         inc_in = fine_inc;
      end
      if (cmd.inc_quick) begin
         inc_in = quick_inc;
      end

      if (cmd.add_phase) begin
         phase_in = phase_sat;
      end

      // Remove the whole part, report the fraction
      if (cmd.take_whole) begin
         phase_in      = PHASE_W'(frac);
         last_alpha_in = alpha_ext[FRAC_BITS+15:FRAC_BITS];
         last_ticks_in = take_ticks;
      end

      if (cmd.load_out) begin
         out_ticks_in = last_ticks_ff;
         out_alpha_in = last_alpha_ff;
         out_step_in  = !steps_left_ff[STEP_W-1];
         out_scale_in = time_scale_ff;
      end
   end

   // Architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff  <= RATE_W'(60);
         max_ticks_ff  <= TICK_W'(10);
         last_time_ff  <= '0;
         phase_ff      <= '0;
         time_scale_ff <= SCALE_ONE;
         steps_left_ff <= STEPS_IDLE;
         last_ticks_ff <= '0;
         last_alpha_ff <= '0;
      end else begin
         tick_rate_ff  <= tick_rate_in;
         max_ticks_ff  <= max_ticks_in;
         last_time_ff  <= last_time_in;
         phase_ff      <= phase_in;
         time_scale_ff <= time_scale_in;
         steps_left_ff <= steps_left_in;
         last_ticks_ff <= last_ticks_in;
         last_alpha_ff <= last_alpha_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      item_mode_ff  <= item_mode_in;
      item_now_ff   <= item_now_in;
      item_steps_ff <= item_steps_in;
      item_scale_ff <= item_scale_in;
      ms_ff         <= ms_in;
      div_x_ff      <= div_x_in;
      qs_ff         <= qs_in;
      acc_ff        <= acc_in;
      inc_ff        <= inc_in;
      out_ticks_ff  <= out_ticks_in;
      out_alpha_ff  <= out_alpha_in;
      out_step_ff   <= out_step_in;
      out_scale_ff  <= out_scale_in;
   end

   assign rsp_ticks       = out_ticks_ff;
   assign rsp_alpha       = out_alpha_ff;
   assign rsp_is_stepping = out_step_ff;
   assign rsp_scale_now   = out_scale_ff;

endmodule

// ===== rtl/core/scaled_fixed_step_tick_accumulator.sv =====
// Fixed-timestep tick accumulator with a Q4.12 time scale and single stepping. Every input
// beat yields exactly one result beat carrying the ticks to run, the Q0.16 interpolation
// alpha, the stepping flag and the current scale. One item is in flight at a time; the
// result waits in an output register, so the next item is taken while it is pending.
// An advance and a skip, which reports no ticks, each make three passes through the shared
// divide-by-1000 unit; advance-quickly goes straight to the phase add, and set-step-count,
// set-scale, stepped advances and unused modes only decode and load the result. An item
// waits to load its result while the sink still holds the previous one. The user must write
// tick_rate and max_ticks through the csr_ port only while no item is in flight; the block
// itself does not enforce it.
module scaled_fixed_step_tick_accumulator import stfta_pkg::*; #(
   parameter int TICK_LIMIT = 1000000,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   stfta_req_if.sink             req_chan,
   stfta_rsp_if.source           rsp_chan,
   input  logic                  csr_we,
   input  csr_idx_type           csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       ctrl_req_ready;
   logic       ctrl_rsp_valid;

   stfta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   stfta_dpath #(
      .TICK_LIMIT (TICK_LIMIT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_chan.mode),
      .req_now_ms      (req_chan.now_ms),
      .req_step_count  (req_chan.step_count),
      .req_scale_value (req_chan.scale_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ticks       (rsp_chan.ticks),
      .rsp_alpha       (rsp_chan.alpha),
      .rsp_is_stepping (rsp_chan.is_stepping),
      .rsp_scale_now   (rsp_chan.scale_now)
   );

   assign req_chan.ready = ctrl_req_ready;
   assign rsp_chan.valid = ctrl_rsp_valid;

`include "scaled_fixed_step_tick_accumulator_defines.svh"

   // Busy after a beat is taken; scale and ticks stay in range
`STFTA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "input taken while an item is in flight")
`STFTA_ASSERT_IMPL(a_scale_in_range, clock, reset, rsp_chan.valid, rsp_chan.scale_now <= SCALE_MAX, "reported scale above 10.0")
`STFTA_ASSERT_IMPL(a_ticks_in_range, clock, reset, rsp_chan.valid, rsp_chan.ticks <= TICK_LIMIT, "reported ticks above limit")

endmodule

// ===== dv/tb_scaled_fixed_step_tick_accumulator.sv =====
`timescale 1ns / 100ps

module tb_scaled_fixed_step_tick_accumulator;
   import stfta_pkg::*;

   localparam int        TICK_CAP    = 1000000;
   localparam int        FRAC        = 16;
   localparam int        STALL_LIMIT = 4000;
   localparam int        HOLD_CYCLES = 300;
   localparam bit [63:0] PHASE_TOP   = (64'd1 << (32 + FRAC)) - 64'd1;

   // Modes five to seven have no function; the block only reports its state
   localparam mode_type MODE_SPARE_FIRST = 3'd5;
   localparam mode_type MODE_SPARE_LAST  = 3'd7;

   typedef struct packed {
      mode_type            mode;
      logic [TIME_W-1:0]   now_ms;
      logic [STEP_W-1:0]   step_count;
      logic [SCALE_W-1:0]  scale_value;
   } tick_req_type;

   typedef struct packed {
      logic [TICK_W-1:0]   ticks;
      logic [ALPHA_W-1:0]  alpha;
      logic                is_stepping;
      logic [SCALE_W-1:0]  scale_now;
   } tick_report_type;

   typedef struct {
      tick_req_type     req;
      bit               typed;
      tick_report_type  want;
   } dir_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   stfta_req_if req_if ();
   stfta_rsp_if rsp_if ();

   // Hand-typed expectation travels with the request beat
   logic             req_typed;
   tick_report_type  req_want;

   bit                calm;
   bit                rsp_hold;
   int                req_beats;
   int                mismatches;
   int                stall_cycles;
   logic [31:0]       stim_time;
   tick_report_type   pending_reports[$];
   dir_beat_type      dir_beats[$];

   // Shadow of the accumulator state and its registers
   logic [RATE_W-1:0]        rate_cfg;
   logic [TICK_W-1:0]        max_cfg;
   logic [TIME_W-1:0]        clk_last;
   logic [47:0]              phase_acc;
   logic [SCALE_W-1:0]       scale_acc;
   logic signed [STEP_W-1:0] steps_left;
   logic [TICK_W-1:0]        ticks_prev;
   logic [ALPHA_W-1:0]       alpha_prev;

   scaled_fixed_step_tick_accumulator #(
      .TICK_LIMIT (TICK_CAP),
      .FRAC_BITS  (FRAC)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Add to the phase, saturating at the top of Q32.16
   function automatic void bump_phase(bit [63:0] inc);
      if (inc > PHASE_TOP - {16'd0, phase_acc}) begin
         phase_acc = PHASE_TOP[47:0];
      end else begin
         phase_acc = phase_acc + inc[47:0];
      end
   endfunction

   // Turn clamped elapsed milliseconds into scaled phase
   function automatic void elapse_ms(logic [TIME_W-1:0] now);
      bit [63:0] ms;
      ms = '0;
      if (now >= clk_last) begin
         ms = now - clk_last;
         if (ms > MS_CAP) ms = MS_CAP;
      end
      clk_last = now;
      bump_phase(((ms * scale_acc * rate_cfg) << FRAC) / (64'd1000 * SCALE_ONE));
   endfunction

   // Strip the whole ticks off the phase, keep the fraction as alpha
   function automatic bit [63:0] split_phase();
      bit [63:0] whole;
      bit [63:0] frac;
      whole = {16'd0, phase_acc} >> FRAC;
      frac = {16'd0, phase_acc} & ((64'd1 << FRAC) - 64'd1);
      phase_acc = frac[47:0];
      alpha_prev = ALPHA_W'((frac << 16) >> FRAC);
      return whole;
   endfunction

   function automatic tick_report_type next_tick_report(tick_req_type it);
      tick_report_type rep;
      bit [63:0]       cap;
      bit [63:0]       whole;
      cap = (max_cfg > TICK_CAP) ? 64'(TICK_CAP) : 64'(max_cfg);
      case (it.mode)
         MODE_ADVANCE: begin
            if (steps_left >= 0) begin
               if (steps_left == 0) begin
                  ticks_prev = '0;
                  alpha_prev = '0;
               end else begin
                  ticks_prev = TICK_W'(1);
                  steps_left = steps_left - STEP_W'(1);
               end
            end else begin
               elapse_ms(it.now_ms);
               whole = split_phase();
               ticks_prev = TICK_W'((whole > cap) ? cap : whole);
            end
         end
         MODE_QUICK: begin
            bump_phase(((cap * scale_acc) << FRAC) / SCALE_ONE);
            whole = split_phase();
            ticks_prev = TICK_W'((whole > TICK_CAP) ? 64'(TICK_CAP) : whole);
         end
         MODE_SKIP: begin
            elapse_ms(it.now_ms);
            ticks_prev = '0;
         end
         MODE_STEPS: begin
            if (it.step_count[STEP_W-1]) begin
               steps_left = STEPS_IDLE;
               clk_last = it.now_ms;
               phase_acc = '0;
               scale_acc = SCALE_ONE;
            end else begin
               steps_left = it.step_count;
            end
         end
         MODE_SCALE: begin
            scale_acc = (it.scale_value > SCALE_MAX) ? SCALE_MAX : it.scale_value;
         end
         default: begin
         end
      endcase
      rep.ticks = ticks_prev;
      rep.alpha = alpha_prev;
      rep.is_stepping = (steps_left >= 0);
      rep.scale_now = scale_acc;
      return rep;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatches++;
   endtask

   // Track register writes, predict each request beat, check each result beat
   always @(posedge clock) begin : scoreboard
      tick_req_type    it;
      tick_report_type want;
      tick_report_type got;
      if (reset) begin
         rate_cfg = RATE_W'(60);
         max_cfg = TICK_W'(10);
         clk_last = '0;
         phase_acc = '0;
         scale_acc = SCALE_ONE;
         steps_left = STEPS_IDLE;
         ticks_prev = '0;
         alpha_prev = '0;
         pending_reports.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_TICK_RATE) rate_cfg = csr_wdata[RATE_W-1:0];
            else if (csr_index == CSR_MAX_TICKS) max_cfg = csr_wdata[TICK_W-1:0];
         end
         if (req_if.valid && req_if.ready) begin
            it.mode = req_if.mode;
            it.now_ms = req_if.now_ms;
            it.step_count = req_if.step_count;
            it.scale_value = req_if.scale_value;
            want = next_tick_report(it);
            if (req_typed) want = req_want;
            pending_reports.push_back(want);
            req_beats++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.ticks = rsp_if.ticks;
            got.alpha = rsp_if.alpha;
            got.is_stepping = rsp_if.is_stepping;
            got.scale_now = rsp_if.scale_now;
            if (pending_reports.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing pending: %p", got));
            end else begin
               want = pending_reports.pop_front();
               if (got.ticks !== want.ticks)
                  report_mismatch($sformatf("ticks got %0d expected %0d",
                                            got.ticks, want.ticks));
               if (got.alpha !== want.alpha)
                  report_mismatch($sformatf("alpha got %0d expected %0d",
                                            got.alpha, want.alpha));
               if (got.is_stepping !== want.is_stepping)
                  report_mismatch($sformatf("is_stepping got %0d expected %0d",
                                            got.is_stepping, want.is_stepping));
               if (got.scale_now !== want.scale_now)
                  report_mismatch($sformatf("scale_now got %0d expected %0d",
                                            got.scale_now, want.scale_now));
            end
         end
      end
   end

   // Abort when no beat moves on either channel for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Result side: random ready bursts, one long hold on request
   initial begin : rsp_side
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   // Offer one request beat, after an optional gap; return once it is taken
   task automatic send_beat(tick_req_type it, bit typed, tick_report_type want);
      int n;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= it.mode;
      req_if.now_ms <= it.now_ms;
      req_if.step_count <= it.step_count;
      req_if.scale_value <= it.scale_value;
      req_typed <= typed;
      req_want <= want;
      n = req_beats;
      do @(negedge clock); while (req_beats == n);
   endtask

   // Stop offering and hold until every pending result has come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   task automatic write_config(logic [RATE_W-1:0] rate, logic [TICK_W-1:0] max_t);
      csr_we <= 1'b1;
      csr_index <= CSR_TICK_RATE;
      csr_wdata <= CSR_DATA_W'(rate);
      @(negedge clock);
      csr_index <= CSR_MAX_TICKS;
      csr_wdata <= CSR_DATA_W'(max_t);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic dir_row(mode_type m, logic [TIME_W-1:0] now, logic [STEP_W-1:0] steps,
                          logic [SCALE_W-1:0] scl, bit typed, logic [TICK_W-1:0] t,
                          logic [ALPHA_W-1:0] a, logic s, logic [SCALE_W-1:0] sc);
      dir_beat_type b;
      b.req.mode = m;
      b.req.now_ms = now;
      b.req.step_count = steps;
      b.req.scale_value = scl;
      b.typed = typed;
      b.want.ticks = t;
      b.want.alpha = a;
      b.want.is_stepping = s;
      b.want.scale_now = sc;
      dir_beats.push_back(b);
   endtask

   // Random beats: mostly clock readings that move forward a little
   task automatic run_random(int n);
      tick_req_type it;
      int           pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) it.mode = MODE_ADVANCE;
         else if (pick < 52) it.mode = MODE_SKIP;
         else if (pick < 62) it.mode = MODE_QUICK;
         else if (pick < 75) it.mode = MODE_STEPS;
         else if (pick < 95) it.mode = MODE_SCALE;
         else it.mode = mode_type'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
         case ($urandom_range(0, 9))
            0: it.now_ms = $urandom();
            1: it.now_ms = stim_time - $urandom_range(1, 500);
            2: it.now_ms = stim_time + $urandom_range(1001, 5000);
            default: it.now_ms = stim_time + $urandom_range(0, 200);
         endcase
         stim_time = it.now_ms;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: it.step_count = STEPS_IDLE;
            4: it.step_count = {1'b1, 16'($urandom())};
            5: it.step_count = STEP_W'($urandom());
            default: it.step_count = STEP_W'($urandom_range(0, 6));
         endcase
         case ($urandom_range(0, 7))
            0: it.scale_value = SCALE_W'($urandom());
            1: it.scale_value = '0;
            2: it.scale_value = SCALE_MAX;
            3: it.scale_value = '1;
            default: it.scale_value = SCALE_W'($urandom_range(0, 16384));
         endcase
         send_beat(it, 1'b0, '0);
      end
   endtask

   initial begin
      logic [RATE_W-1:0] rates[6];
      logic [TICK_W-1:0] maxes[6];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TICK_RATE;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.mode = MODE_ADVANCE;
      req_if.now_ms = '0;
      req_if.step_count = '0;
      req_if.scale_value = '0;
      req_typed = 1'b0;
      req_want = '0;
      calm = 1'b0;
      rsp_hold = 1'b0;
      req_beats = 0;
      mismatches = 0;
      stall_cycles = 0;
      stim_time = '0;

      // Directed beats at reset settings: rate 60, at most 10 ticks
      dir_row(MODE_SPARE_FIRST, 0, 0, 0, 1, 0, 0, 0, SCALE_ONE);
      dir_row(MODE_ADVANCE, 1000, 0, 0, 1, 10, 0, 0, SCALE_ONE);
      dir_row(MODE_ADVANCE, 500, 0, 0, 1, 0, 0, 0, SCALE_ONE);
      dir_row(MODE_ADVANCE, 32'hFFFF_FFFF, '1, '1, 1, 10, 0, 0, SCALE_ONE);
      dir_row(MODE_SKIP, 0, 0, 0, 1, 0, 0, 0, SCALE_ONE);
      dir_row(MODE_SKIP, 16, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_ADVANCE, 33, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_SCALE, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0);
      dir_row(MODE_QUICK, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_ADVANCE, 1033, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_SCALE, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_ADVANCE, 2033, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_SCALE, 0, 0, SCALE_ONE, 0, 0, 0, 0, 0);
      dir_row(MODE_STEPS, 0, 2, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_ADVANCE, 2100, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_ADVANCE, 2200, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_ADVANCE, 2300, 0, 0, 1, 0, 0, 1, SCALE_ONE);
      dir_row(MODE_SKIP, 3000, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_QUICK, 3000, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_STEPS, 0, 17'h0FFFF, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_ADVANCE, 3100, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_STEPS, 5000, STEPS_IDLE, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_STEPS, 0, 17'h10000, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_SCALE, 0, 0, SCALE_MAX, 0, 0, 0, 0, 0);
      dir_row(MODE_STEPS, 0, 0, 0, 0, 0, 0, 0, 0);
      dir_row(MODE_ADVANCE, 100, 0, 0, 1, 0, 0, 1, SCALE_MAX);
      dir_row(MODE_STEPS, 200, STEPS_IDLE, 0, 0, 0, 0, 0, 0);

      // Register settings per phase: low corner, high corner, past the limit, random, reset values
      rates[0] = 1;     maxes[0] = 0;
      rates[1] = 1000;  maxes[1] = TICK_W'(TICK_CAP);
      rates[2] = 1000;  maxes[2] = '1;
      rates[3] = RATE_W'($urandom_range(1, 1000));
      maxes[3] = TICK_W'($urandom_range(0, 40));
      rates[4] = RATE_W'($urandom_range(1, 1000));
      maxes[4] = TICK_W'($urandom_range(0, TICK_CAP));
      rates[5] = 60;    maxes[5] = 10;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_beats[i]) send_beat(dir_beats[i].req, dir_beats[i].typed, dir_beats[i].want);

      for (int p = 0; p < 6; p++) begin
         drain_results();
         if (p == 5) calm = 1'b1;
         write_config(rates[p], maxes[p]);
         if (p == 2) begin
            // Stall the result side so the block backs up into the request side
            run_random(50);
            rsp_hold = 1'b1;
            run_random(58);
         end else if (p == 3) begin
            run_random(54);
            drain_results();
            run_random(54);
         end else begin
            run_random(108);
         end
      end

      // Let stray result beats show up before the verdict
      drain_results();
      repeat (40) @(negedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
